// File: rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTRK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTRK_ASSERT(lbl, prop, msg)
`define PTRK_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/ptrk_pkg.sv
// Shared types and sizes for the per-caller page usage tracker.
// No dependencies.
`timescale 1ns / 1ps
package ptrk_pkg;

  // The table and page map sizes are fixed by the slot and page number port widths.
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int NUM_PAGES_DEF     = 65536;
  localparam int MAX_ORDER_DEF     = 10;
  localparam int PAGE_KB_SHIFT_DEF = 2;

  localparam int TAG_W  = 64;
  localparam int SLOT_W = 10;
  localparam int KB_W   = 32;
  localparam int USE_W  = 11;
  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIS    = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  // Work class decided by the front end.
  typedef enum logic [KIND_W-1:0] {
    K_DIS   = 3'd0,
    K_ALLOC = 3'd1,
    K_FREE  = 3'd2,
    K_READ  = 3'd3,
    K_NOP   = 3'd4
  } kind_t;

endpackage

// File: rtl/ptrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ptrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/ptrk_fifo.sv
// Short register queue between the front end and the execution back end.
// No dependencies.
`timescale 1ns / 1ps
module ptrk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             nonempty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = slot_q[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_q[wp_r] <= wdata;
    end
  end
endmodule

// File: rtl/ptrk_mod.sv
// Remainder by a constant power-of-two divisor, registered: result ready in the
// cycle after start. No dependencies.
`timescale 1ns / 1ps
module ptrk_mod #(
  parameter int IW  = 64,
  parameter int DIV = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [IW-1:0]          din,
  output logic                   done,
  output logic [$clog2(DIV)-1:0] rem
);
  localparam int RW = $clog2(DIV);
  localparam int EW = (IW > RW) ? IW : RW;

  logic          done_r;
  logic [EW-1:0] dext;
  logic [RW-1:0] rem_r;

  assign done = done_r;
  assign dext = EW'(din);
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dext[RW-1:0];
    end
  end
endmodule

// File: rtl/ptrk_front.sv
// Front end: takes input beats, holds the enable register, classifies each item,
// reduces the page number and queues the item. Uses ptrk_pkg and ptrk_mod.
`timescale 1ns / 1ps
module ptrk_front #(
  parameter int MAX_ORDER = ptrk_pkg::MAX_ORDER_DEF,
  parameter int QW        = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_tracking_enabled,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [15:0]                 in_page_index,
  input  logic [3:0]                  in_alloc_order,
  input  logic [ptrk_pkg::TAG_W-1:0]  in_caller_tag,
  input  logic [ptrk_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic                        init_done,
  output logic                        q_push,
  output logic [QW-1:0]               q_data,
  input  logic                        q_full
);
  import ptrk_pkg::*;

  localparam int NUM_PAGES = NUM_PAGES_DEF;
  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int OW        = $clog2(MAX_ORDER + 2);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state_r, state_nxt;
  logic                en_r;
  kind_t               kind_r, kind_w;
  logic [OW-1:0]       ord_r, ord_w;
  logic [TAG_W-1:0]    tag_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PG_W-1:0]     page_r;
  logic                accept, mod_done;
  logic [PG_W-1:0]     mod_rem;

  assign cfg_ready = 1'b1;
  assign in_ready  = init_done && (state_r == F_IDLE);
  assign accept    = in_valid && in_ready;
  assign q_push    = (state_r == F_PUSH);
  assign q_data    = {kind_r, page_r, ord_r, tag_r, slot_r};

  ptrk_mod #(.IW(16), .DIV(NUM_PAGES)) u_page_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .din   (in_page_index),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    if (!en_r) begin
      kind_w = K_DIS;
    end else begin
      case (mode_t'(in_mode))
        MODE_ALLOC: kind_w = K_ALLOC;
        MODE_FREE:  kind_w = K_FREE;
        MODE_READ:  kind_w = K_READ;
        default:    kind_w = K_NOP;
      endcase
    end
    if (5'(in_alloc_order) > 5'(MAX_ORDER)) begin
      ord_w = OW'(MAX_ORDER);
    end else begin
      ord_w = OW'(in_alloc_order);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_MOD;
      F_MOD:   if (mod_done) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      en_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        en_r <= cfg_tracking_enabled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_w;
      ord_r  <= ord_w;
      tag_r  <= in_caller_tag;
      slot_r <= in_entry_slot;
    end
    if (state_r == F_MOD && mod_done) begin
      page_r <= mod_rem;
    end
  end

`include "assert_macros.svh"
  `PTRK_ASSERT(a_push_after_mod, q_push |-> $past(state_r) == F_MOD || $past(q_full), "push without reduced page")
  `PTRK_NEVER(a_no_accept_in_init, accept && !init_done, "item taken during clearing pass")
endmodule

// File: rtl/ptrk_back.sv
// Back end: hash-chain lookup, table update, page owner map and result register.
// Uses ptrk_pkg, ptrk_ram and ptrk_mod.
`timescale 1ns / 1ps
module ptrk_back #(
  parameter int MAX_ORDER     = ptrk_pkg::MAX_ORDER_DEF,
  parameter int PAGE_KB_SHIFT = ptrk_pkg::PAGE_KB_SHIFT_DEF,
  parameter int QW            = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_nonempty,
  input  logic [QW-1:0]              q_data,
  output logic                       q_pop,
  output logic                       init_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [ptrk_pkg::TAG_W-1:0] out_entry_caller,
  output logic signed [ptrk_pkg::KB_W-1:0] out_entry_kb,
  output logic [ptrk_pkg::USE_W-1:0] out_entries_in_use
);
  import ptrk_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int NUM_PAGES     = NUM_PAGES_DEF;
  localparam int PG_W  = $clog2(NUM_PAGES);
  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int XW    = AW + 1;
  localparam int CNW   = MAX_ORDER + 1;
  localparam int CMPW  = (XW > SLOT_W) ? XW : SLOT_W;
  localparam int CLR_N = (NUM_PAGES > TABLE_ENTRIES) ? NUM_PAGES : TABLE_ENTRIES;
  localparam int CW    = $clog2(CLR_N);

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_RDW    = 14'b00000000000100,
    S_HSTART = 14'b00000000001000,
    S_HWAIT  = 14'b00000000010000,
    S_HEAD   = 14'b00000000100000,
    S_WALK   = 14'b00000001000000,
    S_CMP    = 14'b00000010000000,
    S_MISS   = 14'b00000100000000,
    S_OWN    = 14'b00001000000000,
    S_OWNQ   = 14'b00010000000000,
    S_NEXT   = 14'b00100000000000,
    S_OWNW   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [PG_W-1:0]  p_r, p_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt, last_r, last_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt, key_r, key_nxt;
  logic [KB_W-1:0]  add_r, add_nxt;
  logic [XW-1:0]    fill_r, fill_nxt, idx_r, idx_nxt, head_r, head_nxt;
  logic [AW-1:0]    bucket_r, bucket_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  status_t          st_r, st_nxt;
  logic [TAG_W-1:0] caller_r, caller_nxt;
  logic [KB_W-1:0]  kb_r, kb_nxt;

  // Unpacked queue head
  kind_t            qk;
  logic [PG_W-1:0]  qpage;
  logic [OW-1:0]    qord;
  logic [TAG_W-1:0] qtag;
  logic [CMPW-1:0]  qslot;

  // Memory ports
  logic             own_we, own_re, head_we, head_re, ent_we, ent_re, tot_we;
  logic [PG_W-1:0]  own_waddr, own_raddr;
  logic [TAG_W-1:0] own_wdata, own_q;
  logic [AW-1:0]    head_waddr, head_raddr, ent_waddr, ent_raddr, tot_waddr;
  logic [XW-1:0]    head_wdata, head_q, next_q;
  logic [TAG_W-1:0] etag_q;
  logic [KB_W-1:0]  tot_wdata, etot_q, tot_new;
  logic             mod_start, mod_done;
  logic [AW-1:0]    mod_rem;
  logic             last_page;
  logic [PG_W-1:0]  p_inc;

  assign qk    = kind_t'(q_data[QW-1 -: KIND_W]);
  assign qpage = q_data[QW-KIND_W-1 -: PG_W];
  assign qord  = q_data[TAG_W+SLOT_W+OW-1 -: OW];
  assign qtag  = q_data[TAG_W+SLOT_W-1 -: TAG_W];
  assign qslot = CMPW'(q_data[SLOT_W-1:0]);

  assign init_done          = (state_r != S_INIT);
  assign q_pop              = (state_r == S_IDLE) && q_nonempty;
  assign out_valid          = (state_r == S_OUT);
  assign out_status         = st_r;
  assign out_entry_caller   = caller_r;
  assign out_entry_kb       = kb_r;
  assign out_entries_in_use = USE_W'(fill_r);
  assign last_page          = (cnt_r == last_r);
  assign p_inc              = (p_r == PG_W'(NUM_PAGES - 1)) ? '0 : p_r + 1'b1;

  ptrk_mod #(.IW(TAG_W), .DIV(TABLE_ENTRIES)) u_bucket_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .din(key_r), .done(mod_done), .rem(mod_rem)
  );

  ptrk_ram #(.WIDTH(TAG_W), .DEPTH(NUM_PAGES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .re(own_re), .raddr(own_raddr), .rdata(own_q)
  );
  ptrk_ram #(.WIDTH(XW), .DEPTH(TABLE_ENTRIES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_q)
  );
  ptrk_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_ENTRIES)) u_etag (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(tag_r),
    .re(ent_re), .raddr(ent_raddr), .rdata(etag_q)
  );
  ptrk_ram #(.WIDTH(XW), .DEPTH(TABLE_ENTRIES)) u_enext (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(head_r),
    .re(ent_re), .raddr(ent_raddr), .rdata(next_q)
  );
  ptrk_ram #(.WIDTH(KB_W), .DEPTH(TABLE_ENTRIES)) u_etot (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(etot_q)
  );

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    tag_nxt    = tag_r;
    key_nxt    = key_r;
    add_nxt    = add_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    head_nxt   = head_r;
    bucket_nxt = bucket_r;
    clr_nxt    = clr_r;
    st_nxt     = st_r;
    caller_nxt = caller_r;
    kb_nxt     = kb_r;
    own_we     = 1'b0;
    own_re     = 1'b0;
    own_waddr  = p_r;
    own_raddr  = p_r;
    own_wdata  = '0;
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_waddr = bucket_r;
    head_raddr = mod_rem;
    head_wdata = fill_r;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_waddr  = fill_r[AW-1:0];
    ent_raddr  = idx_r[AW-1:0];
    tot_we     = 1'b0;
    tot_waddr  = idx_r[AW-1:0];
    tot_wdata  = add_r;
    mod_start  = 1'b0;
    tot_new    = (kind_r == K_ALLOC) ? etot_q + add_r : etot_q - (KB_W'(1) << PAGE_KB_SHIFT);

    case (state_r)
      S_INIT: begin
        // Clearing pass: every page loses its owner and every bucket empties.
        own_we     = ((CW+1)'(clr_r) < (CW+1)'(NUM_PAGES));
        own_waddr  = clr_r[PG_W-1:0];
        head_we    = ((CW+1)'(clr_r) < (CW+1)'(TABLE_ENTRIES));
        head_waddr = clr_r[AW-1:0];
        head_wdata = XW'(TABLE_ENTRIES);
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_nonempty) begin
          kind_nxt   = qk;
          p_nxt      = qpage;
          tag_nxt    = qtag;
          key_nxt    = qtag;
          cnt_nxt    = '0;
          last_nxt   = (CNW'(1) << qord) - CNW'(1);
          add_nxt    = KB_W'(1) << (6'(qord) + 6'(PAGE_KB_SHIFT));
          st_nxt     = ST_OK;
          caller_nxt = '0;
          kb_nxt     = '0;
          case (qk)
            K_DIS: begin
              st_nxt    = ST_DIS;
              state_nxt = S_OUT;
            end
            K_READ: begin
              if (qslot < CMPW'(fill_r)) begin
                ent_re    = 1'b1;
                ent_raddr = qslot[AW-1:0];
                state_nxt = S_RDW;
              end else begin
                st_nxt    = ST_UNUSED;
                state_nxt = S_OUT;
              end
            end
            K_ALLOC: state_nxt = S_HSTART;
            K_FREE:  state_nxt = S_OWN;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RDW: begin
        caller_nxt = etag_q;
        kb_nxt     = etot_q;
        state_nxt  = S_OUT;
      end
      S_HSTART: begin
        mod_start = 1'b1;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        if (mod_done) begin
          head_re    = 1'b1;
          bucket_nxt = mod_rem;
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        idx_nxt   = head_q;
        head_nxt  = head_q;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // Chains only point to lower, already written slots.
        if (idx_r < fill_r) begin
          ent_re    = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_CMP: begin
        if (etag_q == key_r) begin
          tot_we     = 1'b1;
          tot_wdata  = tot_new;
          caller_nxt = key_r;
          kb_nxt     = tot_new;
          if (kind_r == K_ALLOC) begin
            state_nxt = (tag_r != '0) ? S_OWNW : S_OUT;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          idx_nxt   = next_q;
          state_nxt = S_WALK;
        end
      end
      S_MISS: begin
        if (kind_r == K_ALLOC) begin
          caller_nxt = tag_r;
          if (fill_r >= XW'(TABLE_ENTRIES)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_OUT;
          end else begin
            // New entry goes to the head of its bucket chain.
            ent_we    = 1'b1;
            tot_we    = 1'b1;
            tot_waddr = fill_r[AW-1:0];
            head_we   = 1'b1;
            fill_nxt  = fill_r + 1'b1;
            kb_nxt    = add_r;
            state_nxt = (tag_r != '0) ? S_OWNW : S_OUT;
          end
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_OWN: begin
        own_re    = 1'b1;
        state_nxt = S_OWNQ;
      end
      S_OWNQ: begin
        own_we = 1'b1;
        if (own_q != '0) begin
          key_nxt   = own_q;
          state_nxt = S_HSTART;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_page) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          p_nxt     = p_inc;
          state_nxt = S_OWN;
        end
      end
      S_OWNW: begin
        own_we    = 1'b1;
        own_wdata = tag_r;
        if (last_page) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          p_nxt   = p_inc;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fill_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    tag_r    <= tag_nxt;
    key_r    <= key_nxt;
    add_r    <= add_nxt;
    idx_r    <= idx_nxt;
    head_r   <= head_nxt;
    bucket_r <= bucket_nxt;
    st_r     <= st_nxt;
    caller_r <= caller_nxt;
    kb_r     <= kb_nxt;
  end

`include "assert_macros.svh"
  `PTRK_ASSERT(a_fill_bound, fill_r <= XW'(TABLE_ENTRIES), "fill count beyond table size")
  `PTRK_ASSERT(a_fill_step, fill_r == $past(fill_r) || fill_r == $past(fill_r) + 1'b1, "fill count jumped")
  `PTRK_ASSERT(a_cmp_in_range, state_r == S_CMP |-> idx_r < fill_r, "chain walk read an unfilled slot")
  `PTRK_NEVER(a_pop_in_init, q_pop && !init_done, "queue popped during clearing pass")
endmodule

// File: rtl/per_caller_page_usage_tracker_core.sv
// Top level of the per-caller page usage tracker: front end, queue and back end.
// Uses ptrk_pkg, ptrk_front, ptrk_fifo and ptrk_back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   mode, page_index, alloc_order, caller_tag, entry_slot
//   out      output     out_valid / out_ready status, entry_caller, entry_kb, entries_in_use
//   cfg      input      cfg_valid / cfg_ready tracking_enabled
//
// After reset a clearing pass over 65536 addresses (the larger of the page count and the
// table size) empties the owner map and bucket heads; no input beat is taken until it ends.
// The front end takes one item at a time: accept, page reduction, then queue push, which
// waits while the queue is full. Back end: a read fetches its slot directly; an allocate
// walks its bucket chain, then writes 2^order page owners (none for a zero tag); a free
// reads each page owner and walks each found owner's chain. The result waits on out_ready.
// A two-entry queue lets the front end take beats while a result waits on out_ready.
`timescale 1ns / 1ps
module per_caller_page_usage_tracker_core #(
  parameter int MAX_ORDER     = ptrk_pkg::MAX_ORDER_DEF,
  parameter int PAGE_KB_SHIFT = ptrk_pkg::PAGE_KB_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_tracking_enabled,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [15:0]                 in_page_index,
  input  logic [3:0]                  in_alloc_order,
  input  logic [ptrk_pkg::TAG_W-1:0]  in_caller_tag,
  input  logic [ptrk_pkg::SLOT_W-1:0] in_entry_slot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [ptrk_pkg::TAG_W-1:0]  out_entry_caller,
  output logic signed [ptrk_pkg::KB_W-1:0] out_entry_kb,
  output logic [ptrk_pkg::USE_W-1:0]  out_entries_in_use
);
  import ptrk_pkg::*;

  localparam int QW = KIND_W + $clog2(NUM_PAGES_DEF) + $clog2(MAX_ORDER + 2) + TAG_W + SLOT_W;

  logic          q_push, q_full, q_pop, q_nonempty, init_done;
  logic [QW-1:0] q_wdata, q_rdata;

  ptrk_front #(.MAX_ORDER(MAX_ORDER), .QW(QW)) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_tracking_enabled (cfg_tracking_enabled),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_page_index        (in_page_index),
    .in_alloc_order       (in_alloc_order),
    .in_caller_tag        (in_caller_tag),
    .in_entry_slot        (in_entry_slot),
    .init_done            (init_done),
    .q_push               (q_push),
    .q_data               (q_wdata),
    .q_full               (q_full)
  );

  ptrk_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  ptrk_back #(
    .MAX_ORDER     (MAX_ORDER),
    .PAGE_KB_SHIFT (PAGE_KB_SHIFT),
    .QW            (QW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_nonempty         (q_nonempty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .init_done          (init_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_caller   (out_entry_caller),
    .out_entry_kb       (out_entry_kb),
    .out_entries_in_use (out_entries_in_use)
  );
endmodule
